### src/keyed_square_pair_cipher_defines.svh
// Assertion macros shared by the checker file of the pair cipher.
// No dependencies; include by bare file name.
`ifndef KEYED_SQUARE_PAIR_CIPHER_DEFINES_SVH
`define KEYED_SQUARE_PAIR_CIPHER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KSPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KSPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/kspc_pkg.sv
// Shared constants, register indexes and types of the keyed square pair cipher.
// No dependencies.
package kspc_pkg;

	localparam int SIDE_DEF   = 5;
	localparam int KEY_BYTES  = 25;
	localparam int CHAR_W     = 8;
	localparam int KEY_LEN_W  = 5;
	localparam int KEY_IDX_W  = 5;
	localparam int KEY_W      = KEY_BYTES * CHAR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_3 = 3'd4;

	// filler values count up from 'a'
	localparam logic [CHAR_W-1:0] FILL_START = 8'h61;

	// register reset values
	localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = 5'd1;
	localparam logic [CHAR_W-1:0]    KEY_BYTE0_RST  = 8'h61;

	typedef logic [CHAR_W-1:0] char_t;

	// compare results of one cell against both plaintext bytes
	typedef struct packed {
		logic first;
		logic second;
	} match_t;

	// square builder to cell chain
	typedef struct packed {
		logic  shift;
		char_t value;
		logic  done;
	} fill_t;

endpackage

### src/kspc_cell.sv
// One cell of the square: holds a byte, shifts it on to the next cell down
// while the square is built, and compares it against both bytes of a pair.
// Depends on kspc_pkg.
module kspc_cell (
	input  logic            clk,
	input  logic            shift,
	input  kspc_pkg::char_t shift_in,
	input  kspc_pkg::char_t first_char,
	input  kspc_pkg::char_t second_char,
	output kspc_pkg::char_t value,
	output kspc_pkg::match_t match
);

	kspc_pkg::char_t value_q;

	// cell byte, loaded from the neighbour above during a build
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= shift_in;
		end
	end

	assign value        = value_q;
	assign match.first  = (value_q == first_char);
	assign match.second = (value_q == second_char);

endmodule

### src/kspc_fill.sv
// Square builder: produces the key bytes and then the filler bytes in cell
// order, one byte per shift, skipping filler values held by the key.
// Depends on kspc_pkg.
module kspc_fill #(
	parameter int SIDE = kspc_pkg::SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [kspc_pkg::KEY_LEN_W-1:0] key_length,
	input  logic [kspc_pkg::KEY_W-1:0]     key,
	output kspc_pkg::fill_t               fill
);

	localparam int CELLS = SIDE * SIDE;
	localparam int LIM   = (CELLS < kspc_pkg::KEY_BYTES) ? CELLS : kspc_pkg::KEY_BYTES;
	localparam int POS_W = $clog2(CELLS + 1);

	logic [POS_W-1:0] pos_q;
	kspc_pkg::char_t  ch_q;
	logic             busy_q;

	logic [POS_W-1:0] klen;
	logic             take_key;
	logic             hit;
	kspc_pkg::char_t  kbyte;

	// key byte select by position
	function automatic kspc_pkg::char_t key_byte(
		input logic [kspc_pkg::KEY_W-1:0]     k,
		input logic [kspc_pkg::KEY_IDX_W-1:0] n
	);
		kspc_pkg::char_t b;
		b = '0;
		for (int i = 0; i < kspc_pkg::KEY_BYTES; i++) begin
			if (n == kspc_pkg::KEY_IDX_W'(i)) begin
				b = k[i*kspc_pkg::CHAR_W +: kspc_pkg::CHAR_W];
			end
		end
		return b;
	endfunction

	// placed key count, saturated to the square
	always_comb begin
		if (key_length > LIM) begin
			klen = POS_W'(LIM);
		end else begin
			klen = POS_W'(key_length);
		end
	end

	// is the filler candidate one of the placed key bytes
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < kspc_pkg::KEY_BYTES; i++) begin
			if ((POS_W'(i) < klen) &&
			    (key[i*kspc_pkg::CHAR_W +: kspc_pkg::CHAR_W] == ch_q)) begin
				hit = 1'b1;
			end
		end
	end

	assign take_key   = (pos_q < klen);
	assign kbyte      = key_byte(key, pos_q[kspc_pkg::KEY_IDX_W-1:0]);
	assign fill.shift = busy_q && (take_key || !hit);
	assign fill.value = take_key ? kbyte : ch_q;
	assign fill.done  = !busy_q;

	// build sequencer: position and filler candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			ch_q   <= kspc_pkg::FILL_START;
		end else if (restart) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			ch_q   <= kspc_pkg::FILL_START;
		end else if (busy_q) begin
			if (fill.shift) begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q == POS_W'(CELLS - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (!take_key) begin
				ch_q <= ch_q + kspc_pkg::CHAR_W'(1);
			end
		end
	end

endmodule

### src/kspc_pair.sv
// Pair resolver: picks the last matching cell of each byte, works out the
// shared row or column and selects the rectangle corners.
// Depends on kspc_pkg.
module kspc_pair #(
	parameter int SIDE = kspc_pkg::SIDE_DEF
) (
	input  logic [SIDE*SIDE-1:0]                       eq1,
	input  logic [SIDE*SIDE-1:0]                       eq2,
	input  logic [SIDE*SIDE-1:0][kspc_pkg::CHAR_W-1:0] square,
	input  kspc_pkg::char_t                            first_char,
	input  kspc_pkg::char_t                            second_char,
	input  logic                                       second_present,
	output kspc_pkg::char_t                            first_out,
	output kspc_pkg::char_t                            second_out
);

	localparam int CELLS = SIDE * SIDE;

	logic [CELLS-1:0] m1, m2;
	logic [SIDE-1:0]  row1, row2, col1, col2;
	kspc_pkg::char_t  corner1, corner2;
	logic             found, same, share;

	// last match wins: a cell counts only if no higher cell matches
	always_comb begin
		for (int i = 0; i < CELLS; i++) begin
			m1[i] = eq1[i] && ((eq1 >> (i + 1)) == '0);
			m2[i] = eq2[i] && ((eq2 >> (i + 1)) == '0);
		end
	end

	// row and column of each match, one-hot
	always_comb begin
		row1 = '0;
		row2 = '0;
		col1 = '0;
		col2 = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int k = 0; k < SIDE; k++) begin
				row1[r] = row1[r] | m1[r*SIDE + k];
				row2[r] = row2[r] | m2[r*SIDE + k];
				col1[k] = col1[k] | m1[r*SIDE + k];
				col2[k] = col2[k] | m2[r*SIDE + k];
			end
		end
	end

	// corners: own row, other byte's column
	always_comb begin
		corner1 = '0;
		corner2 = '0;
		for (int i = 0; i < CELLS; i++) begin
			corner1 = corner1 |
			          (square[i] & {kspc_pkg::CHAR_W{row1[i/SIDE] & col2[i%SIDE]}});
			corner2 = corner2 |
			          (square[i] & {kspc_pkg::CHAR_W{row2[i/SIDE] & col1[i%SIDE]}});
		end
	end

	assign found = (|m1) && (|m2);
	assign same  = |(m1 & m2);
	assign share = (|(row1 & row2)) || (|(col1 & col2));

	// result select
	always_comb begin
		first_out  = first_char;
		second_out = second_char;
		if (!second_present) begin
			second_out = '0;
		end else if (found && !same) begin
			if (share) begin
				first_out  = second_char;
				second_out = first_char;
			end else begin
				first_out  = corner1;
				second_out = corner2;
			end
		end
	end

endmodule

### src/keyed_square_pair_cipher.sv
// Top level of the keyed square pair cipher: configuration registers, square
// builder, cell chain, pair resolver and the input and output registers.
// Depends on kspc_pkg, kspc_cell, kspc_fill and kspc_pair.
//
//   channel | signals                          | word
//   --------+----------------------------------+-----------------------------------
//   input   | s_tvalid s_tready s_tdata s_tuser| byte pair, second-byte flag
//   output  | m_tvalid m_tready m_tdata m_tuser| cipher pair, second-byte flag
//   config  | cfg_valid cfg_ready cfg_index    | register write, 64-bit data
//
// A pair is registered at acceptance and its result is then registered in the
// output register; the resolver compares against all cells at once, so one pair
// per cycle is sustained while the output is not stalled and no rebuild runs.
// After reset and after each write to a key register the cell chain is rebuilt,
// one byte per shift; s_tready stays low meanwhile.
// A stalled output holds its word and the input stage still takes one pair.
module keyed_square_pair_cipher #(
	parameter int SIDE = kspc_pkg::SIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,   // first_char, second_char
	input  logic                               s_tuser,   // second_present
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [15:0]                        m_tdata,   // first_out, second_out
	output logic                               m_tuser,   // second_out_valid
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kspc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kspc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CELLS = SIDE * SIDE;
	localparam int CW    = kspc_pkg::CHAR_W;
	localparam int DW    = kspc_pkg::CFG_DATA_W;

	logic [kspc_pkg::KEY_LEN_W-1:0] key_length_q;
	logic [kspc_pkg::KEY_W-1:0]     key_q;
	logic                           cfg_hit;

	kspc_pkg::fill_t  fill;
	kspc_pkg::char_t  cell_in  [CELLS];
	kspc_pkg::char_t  cell_val [CELLS];
	kspc_pkg::match_t cell_match [CELLS];
	logic [CELLS-1:0]          eq1, eq2;
	logic [CELLS-1:0][CW-1:0]  square;

	logic            valid_s1;
	kspc_pkg::char_t c1_s1, c2_s1;
	logic            present_s1;
	kspc_pkg::char_t o1, o2;

	logic            out_valid_q;
	logic [15:0]     out_data_q;
	logic            out_user_q;
	logic            advance;

	// configuration port, always ready
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index <= kspc_pkg::REG_KEY_BYTES_3);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= kspc_pkg::KEY_LENGTH_RST;
			key_q        <= kspc_pkg::KEY_W'(kspc_pkg::KEY_BYTE0_RST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kspc_pkg::REG_KEY_LENGTH:  key_length_q <= cfg_data[kspc_pkg::KEY_LEN_W-1:0];
				kspc_pkg::REG_KEY_BYTES_0: key_q[0*DW +: DW] <= cfg_data;
				kspc_pkg::REG_KEY_BYTES_1: key_q[1*DW +: DW] <= cfg_data;
				kspc_pkg::REG_KEY_BYTES_2: key_q[2*DW +: DW] <= cfg_data;
				kspc_pkg::REG_KEY_BYTES_3: key_q[3*DW +: CW] <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// square builder
	kspc_fill #(
		.SIDE(SIDE)
	) u_fill (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_hit),
		.key_length (key_length_q),
		.key        (key_q),
		.fill       (fill)
	);

	// cell chain: new bytes enter at the top cell and move down
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == CELLS - 1) begin : g_top
			assign cell_in[i] = fill.value;
		end else begin : g_mid
			assign cell_in[i] = cell_val[i+1];
		end

		kspc_cell u_cell (
			.clk         (clk),
			.shift       (fill.shift),
			.shift_in    (cell_in[i]),
			.first_char  (c1_s1),
			.second_char (c2_s1),
			.value       (cell_val[i]),
			.match       (cell_match[i])
		);

		assign eq1[i]    = cell_match[i].first;
		assign eq2[i]    = cell_match[i].second;
		assign square[i] = cell_val[i];
	end

	kspc_pair #(
		.SIDE(SIDE)
	) u_pair (
		.eq1            (eq1),
		.eq2            (eq2),
		.square         (square),
		.first_char     (c1_s1),
		.second_char    (c2_s1),
		.second_present (present_s1),
		.first_out      (o1),
		.second_out     (o2)
	);

	// flow control
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = fill.done && (!valid_s1 || advance);

	// valid bits of input stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			c1_s1      <= s_tdata[CW-1:0];
			c2_s1      <= s_tdata[2*CW-1:CW];
			present_s1 <= s_tuser;
		end
		if (advance && valid_s1) begin
			out_data_q <= {o2, o1};
			out_user_q <= present_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

### src/kspc_checker.sv
// Port-level checks of the keyed square pair cipher, bound to the top level.
// Depends on kspc_pkg and keyed_square_pair_cipher_defines.svh.
`include "keyed_square_pair_cipher_defines.svh"

module kspc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [15:0]                     m_tdata,
	input logic                            m_tuser,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [kspc_pkg::CFG_IDX_W-1:0]  cfg_index
);

	// a stalled output word holds
	`KSPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// odd trailing byte: second output byte is zero
	`KSPC_ASSERT_NOW(a_odd_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata[15:8] == 8'h00, "second byte not zero on odd word")

	// a key register write starts a rebuild that blocks input
	`KSPC_ASSERT_NEXT(a_cfg_rebuild, clk, arst_n, cfg_valid && cfg_ready && (cfg_index <= kspc_pkg::REG_KEY_BYTES_3), !s_tready, "input ready right after a register write")

endmodule

bind keyed_square_pair_cipher kspc_checker u_checker (.*);

### tb/keyed_square_pair_cipher_tb.sv
// Self-checking testbench of the keyed square pair cipher: drives byte pairs and key writes,
// predicts each cipher word from its own copy of the square and checks every output word.
// Depends on kspc_pkg and keyed_square_pair_cipher.
module keyed_square_pair_cipher_tb;

	localparam int SIDE  = kspc_pkg::SIDE_DEF;
	localparam int CELLS = SIDE * SIDE;
	localparam int CW    = kspc_pkg::CHAR_W;
	localparam int IW    = kspc_pkg::CFG_IDX_W;
	localparam int DW    = kspc_pkg::CFG_DATA_W;
	localparam int LW    = kspc_pkg::KEY_LEN_W;

	typedef struct packed {
		kspc_pkg::char_t first;
		kspc_pkg::char_t second;
		logic            second_valid;
	} cipher_pair_t;

	typedef struct {
		logic [IW-1:0] index;
		logic [DW-1:0] value;
	} reg_write_t;

	// expected cipher words, worked out from a private copy of the key registers
	class cipher_scoreboard;
		logic [LW-1:0]   key_len;
		logic [DW-1:0]   key_word[3];
		kspc_pkg::char_t last_key;
		kspc_pkg::char_t square[CELLS];
		cipher_pair_t    cipher_q[$];
		int              errors;

		function new();
			key_len     = kspc_pkg::KEY_LENGTH_RST;
			key_word[0] = DW'(kspc_pkg::KEY_BYTE0_RST);
			key_word[1] = '0;
			key_word[2] = '0;
			last_key    = '0;
			errors      = 0;
			build_square();
		endfunction

		function kspc_pkg::char_t key_byte(int n);
			if (n == kspc_pkg::KEY_BYTES - 1)
				return last_key;
			return key_word[n / 8][(n % 8) * 8 +: 8];
		endfunction

		function int placed_count();
			int lim;
			lim = (CELLS < kspc_pkg::KEY_BYTES) ? CELLS : kspc_pkg::KEY_BYTES;
			return (int'(key_len) > lim) ? lim : int'(key_len);
		endfunction

		function bit held_by_key(kspc_pkg::char_t v, int klen);
			for (int i = 0; i < klen; i++)
				if (key_byte(i) == v)
					return 1'b1;
			return 1'b0;
		endfunction

		// key bytes first, then filler counting up from 'a' past any key value
		function void build_square();
			int              klen;
			kspc_pkg::char_t fill;
			klen = placed_count();
			fill = kspc_pkg::FILL_START;
			for (int pos = 0; pos < CELLS; pos++) begin
				if (pos < klen) begin
					square[pos] = key_byte(pos);
				end else begin
					while (held_by_key(fill, klen))
						fill++;
					square[pos] = fill;
					fill++;
				end
			end
		endfunction

		function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
			case (idx)
				kspc_pkg::REG_KEY_LENGTH:  key_len     = val[LW-1:0];
				kspc_pkg::REG_KEY_BYTES_0: key_word[0] = val;
				kspc_pkg::REG_KEY_BYTES_1: key_word[1] = val;
				kspc_pkg::REG_KEY_BYTES_2: key_word[2] = val;
				kspc_pkg::REG_KEY_BYTES_3: last_key    = val[CW-1:0];
				default: return;
			endcase
			build_square();
		endfunction

		// last cell holding v, -1 when absent
		function int locate(kspc_pkg::char_t v);
			int found;
			found = -1;
			for (int pos = 0; pos < CELLS; pos++)
				if (square[pos] == v)
					found = pos;
			return found;
		endfunction

		function cipher_pair_t encipher(kspc_pkg::char_t first, kspc_pkg::char_t second,
				logic present);
			cipher_pair_t res;
			int           p1;
			int           p2;
			res.first        = first;
			res.second       = second;
			res.second_valid = 1'b1;
			if (!present) begin
				res.second       = '0;
				res.second_valid = 1'b0;
				return res;
			end
			p1 = locate(first);
			p2 = locate(second);
			if (p1 >= 0 && p2 >= 0 && p1 != p2) begin
				if (p1 / SIDE == p2 / SIDE || p1 % SIDE == p2 % SIDE) begin
					// shared row or column: swap
					res.first  = second;
					res.second = first;
				end else begin
					// rectangle: own row, partner's column
					res.first  = square[(p1 / SIDE) * SIDE + p2 % SIDE];
					res.second = square[(p2 / SIDE) * SIDE + p1 % SIDE];
				end
			end
			return res;
		endfunction

		function void note_pair(kspc_pkg::char_t first, kspc_pkg::char_t second,
				logic present);
			cipher_q.push_back(encipher(first, second, present));
		endfunction

		function int pending();
			return cipher_q.size();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [15:0] data, logic user);
			cipher_pair_t want;
			if (cipher_q.size() == 0) begin
				report($sformatf("unexpected word data %h user %b", data, user));
				return;
			end
			want = cipher_q.pop_front();
			if (data[7:0] !== want.first)
				report($sformatf("first_out %h, want %h", data[7:0], want.first));
			if (data[15:8] !== want.second)
				report($sformatf("second_out %h, want %h", data[15:8], want.second));
			if (user !== want.second_valid)
				report($sformatf("second_out_valid %b, want %b", user, want.second_valid));
		endtask
	endclass

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          s_tvalid  = 1'b0;
	logic          s_tready;
	logic [15:0]   s_tdata   = '0;   // first_char, second_char
	logic          s_tuser   = 1'b0; // second_present
	logic          m_tvalid;
	logic          m_tready  = 1'b0;
	logic [15:0]   m_tdata;          // first_out, second_out
	logic          m_tuser;          // second_out_valid
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data  = '0;

	cipher_scoreboard sb = new();
	bit               quiet = 1'b0;

	keyed_square_pair_cipher #(.SIDE(SIDE)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// output side: check each word taken, stall in random bursts
	initial begin : out_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata, m_tuser);
			if (stall_left > 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 7);
			m_tready <= (stall_left == 0);
		end
	end

	task automatic send_pair(input kspc_pkg::char_t first, input kspc_pkg::char_t second,
			input logic present);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {second, first};
		s_tuser  <= present;
		do @(posedge clk); while (!s_tready);
		sb.note_pair(first, second, present);
	endtask

	// hold the input side until every expected word has come out
	task automatic await_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic program_regs(input reg_write_t writes[$]);
		await_results();
		repeat (4) @(posedge clk);
		foreach (writes[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= writes[i].index;
			cfg_data  <= writes[i].value;
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(writes[i].index, writes[i].value);
		end
		cfg_valid <= 1'b0;
	endtask

	// key bytes cluster round the filler range so repeats and skips are common
	function automatic kspc_pkg::char_t draw_key_byte();
		case ($urandom_range(0, 4))
			0, 1, 2: return kspc_pkg::FILL_START + CW'($urandom_range(0, 25));
			3:       return kspc_pkg::FILL_START - 8'd6 + CW'($urandom_range(0, 38));
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic [DW-1:0] draw_key_word();
		logic [DW-1:0] w;
		for (int i = 0; i < 8; i++)
			w[i * 8 +: 8] = draw_key_byte();
		return w;
	endfunction

	// mostly bytes that sit in the square, some strays
	function automatic kspc_pkg::char_t draw_char();
		case ($urandom_range(0, 19))
			0, 1:    return CW'($urandom);
			2, 3, 4: return kspc_pkg::FILL_START + CW'($urandom_range(0, 31));
			default: return sb.square[$urandom_range(0, CELLS - 1)];
		endcase
	endfunction

	task automatic send_random_pairs(input int count);
		kspc_pkg::char_t first;
		kspc_pkg::char_t second;
		for (int i = 0; i < count; i++) begin
			if (!quiet && $urandom_range(0, 149) == 0)
				await_results();
			first  = draw_char();
			second = ($urandom_range(0, 9) == 0) ? first : draw_char();
			send_pair(first, second, $urandom_range(0, 9) != 0);
		end
	endtask

	task automatic random_key_phase(input int count);
		reg_write_t    writes[$];
		logic [DW-1:0] len_word;
		len_word = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0:       len_word[LW-1:0] = '0;
			1:       len_word[LW-1:0] = LW'(kspc_pkg::KEY_BYTES);
			2:       len_word[LW-1:0] = '1;
			default: len_word[LW-1:0] = LW'($urandom_range(1, kspc_pkg::KEY_BYTES - 1));
		endcase
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_0, draw_key_word()});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_1, draw_key_word()});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_2, draw_key_word()});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_3,
			{{(DW - CW){$urandom_range(0, 1) == 1'b1}}, draw_key_byte()}});
		writes.push_back('{kspc_pkg::REG_KEY_LENGTH, len_word});
		if ($urandom_range(0, 3) == 0)
			writes.push_back('{IW'($urandom_range(kspc_pkg::REG_KEY_BYTES_3 + 1,
				2 ** IW - 1)), {$urandom, $urandom}});
		program_regs(writes);
		send_random_pairs(count);
	endtask

	initial begin : stimulus
		reg_write_t writes[$];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset square: 'a' then b..y
		send_pair("a", "b", 1'b1);         // same row
		send_pair("a", "f", 1'b1);         // same column
		send_pair("g", "a", 1'b1);         // rectangle
		send_pair("y", "a", 1'b1);         // opposite corners
		send_pair("m", "m", 1'b1);         // same cell
		send_pair("z", "a", 1'b1);         // first byte absent
		send_pair("a", 8'hff, 1'b1);       // second byte absent
		send_pair(8'hff, 8'h00, 1'b0);     // odd trailing byte
		send_pair(8'h00, 8'hff, 1'b0);
		send_pair("e", "u", 1'b1);

		// zero key length: whole square is filler, key words ignored
		writes = {};
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_0, '1});
		writes.push_back('{kspc_pkg::REG_KEY_LENGTH, {{(DW - LW){1'b1}}, 5'd0}});
		program_regs(writes);
		send_pair("a", "y", 1'b1);
		send_pair("c", "q", 1'b1);

		// full key of repeated extremes: no filler, last match wins
		writes = {};
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_0, 64'h00ff_00ff_00ff_00ff});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_1, 64'h6161_6161_6262_6262});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_2, 64'hff00_ff00_ff00_ff00});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_3, 64'hffff_ffff_ffff_ff63});
		writes.push_back('{kspc_pkg::REG_KEY_LENGTH, 64'd25});
		program_regs(writes);
		send_pair(8'h00, 8'hff, 1'b1);
		send_pair("a", "b", 1'b1);
		send_pair("c", 8'h00, 1'b1);
		send_pair("b", "c", 1'b1);

		// over-long key length saturates; spare indexes must not land
		writes = {};
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_0, 64'h7271_7a79_7877_7675});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_1, 64'h6a69_6867_6665_6463});
		writes.push_back('{kspc_pkg::REG_KEY_BYTES_2, 64'h3736_3534_3332_3130});
		writes.push_back('{kspc_pkg::REG_KEY_LENGTH, 64'd31});
		for (int i = kspc_pkg::REG_KEY_BYTES_3 + 1; i < 2 ** IW; i++)
			writes.push_back('{IW'(i), {$urandom, $urandom}});
		program_regs(writes);
		send_random_pairs(5);

		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 9)
				quiet = 1'b1;
			random_key_phase(128);
		end

		// wind down with a bound
		s_tvalid <= 1'b0;
		for (int i = 0; i < 4000 && sb.pending() != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d cipher words never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/kspc_pkg.sv
src/kspc_cell.sv
src/kspc_fill.sv
src/kspc_pair.sv
src/keyed_square_pair_cipher.sv
src/kspc_checker.sv
tb/keyed_square_pair_cipher_tb.sv
